### rtl/tga_rle_pkg.sv
package tga_rle_pkg;

    // Register map of the configuration port.
    localparam int unsigned ADDR_WIDTH = 3;
    localparam int unsigned DATA_WIDTH = 32;

    // Register indexes, as selected by paddr[2].
    localparam logic REG_RLE_ENABLE   = 1'b0;
    localparam logic REG_PIXEL_FORMAT = 1'b1;

    // Pixel format codes. The unused code behaves as the 16-bit word format.
    localparam logic [1:0] FMT_WORD16 = 2'd0;
    localparam logic [1:0] FMT_BGR24  = 2'd1;
    localparam logic [1:0] FMT_BGRA32 = 2'd2;

    // Packet header fields.
    localparam int unsigned RUN_FLAG_BIT = 7;
    localparam int unsigned COUNT_WIDTH  = 7;

    localparam int unsigned BYTE_WIDTH   = 8;
    localparam int unsigned ACC_WIDTH    = 24;
    localparam int unsigned WORD_WIDTH   = 16;
    localparam int unsigned REPEAT_WIDTH = 8;

    // Index of the byte that completes a pixel in the given format.
    function automatic logic [1:0] last_position(input logic [1:0] fmt);
        logic [1:0] pos;
        begin
            unique case (fmt)
                FMT_BGR24:  pos = 2'd2;
                FMT_BGRA32: pos = 2'd3;
                default:    pos = 2'd1;
            endcase
            return pos;
        end
    endfunction

    // Final pixel word: the raw 16-bit word, or BGR truncated to RGB555.
    function automatic logic [WORD_WIDTH-1:0] finished_word(
        input logic [1:0]           fmt,
        input logic [ACC_WIDTH-1:0] acc
    );
        logic [WORD_WIDTH-1:0] word;
        begin
            if (fmt == FMT_BGR24 || fmt == FMT_BGRA32)
            begin
                word = {1'b0, acc[23:19], acc[15:11], acc[7:3]};
            end
            else
            begin
                word = acc[WORD_WIDTH-1:0];
            end
            return word;
        end
    endfunction

endpackage

### rtl/tga_rle_pixel_decoder.sv
// Targa RLE pixel decoder. Feed it the pixel-data bytes of a Targa image, one
// byte per slave transaction, after software has parsed the file header and
// programmed the two registers over the APB port (rle_enable at byte address
// 0, pixel_format at byte address 4; 0 = 16-bit word, 1 = 24-bit BGR,
// 2 = 32-bit BGRA, 3 acts as 16-bit). In RLE mode each packet begins with a
// header byte that is consumed silently: bit 7 set means the following pixel
// stands for (low 7 bits + 1) image pixels, clear means that many raw pixels
// follow. Each finished pixel leaves as one master transaction carrying the
// pixel word (raw 16-bit word or RGB555, alpha dropped) and its repeat count,
// which is 1 for every pixel outside a run. The decoder takes one byte per
// clock cycle with no bubbles: the whole update of the packet and pixel state
// is combinational logic, and the single output register is refilled in the
// same cycle in which its previous transaction is taken, so the input only
// stalls while a finished pixel waits downstream. A result appears in the
// output register the cycle after the byte that completes the pixel.
// Registers should be written only while no byte is in flight; a write leaves
// the decoding state untouched.
module tga_rle_pixel_decoder (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // APB configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tga_rle_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [tga_rle_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic [tga_rle_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,

    // Byte stream in. tdata: data_byte[7:0].
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,

    // Pixel stream out. tdata: pixel_word[15:0], repeat_count[23:16].
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [23:0]                          m_axis_tdata
);
    import tga_rle_pkg::*;

    // Configuration registers.
    logic       rle_enable_reg;
    logic [1:0] pixel_format_reg;

    // Packet and pixel assembly state.
    logic                    awaiting_header_reg, awaiting_header_next;
    logic [COUNT_WIDTH-1:0]  raw_remaining_reg,   raw_remaining_next;
    logic                    in_run_reg,          in_run_next;
    logic [REPEAT_WIDTH-1:0] run_length_reg,      run_length_next;
    logic [1:0]              byte_position_reg,   byte_position_next;
    logic [ACC_WIDTH-1:0]    pixel_acc_reg,       pixel_acc_next;

    // Output register.
    logic                    out_valid_reg,       out_valid_next;
    logic [WORD_WIDTH-1:0]   out_word_reg,        out_word_next;
    logic [REPEAT_WIDTH-1:0] out_count_reg,       out_count_next;

    logic cfg_write;
    logic in_accept;
    logic emit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Reads return the register addressed by paddr[2], zero extended.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_PIXEL_FORMAT)
        begin
            prdata[1:0] = pixel_format_reg;
        end
        else
        begin
            prdata[0] = rle_enable_reg;
        end
    end

    // A new byte is taken whenever the output register is empty or is being
    // emptied in this cycle.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        awaiting_header_next = awaiting_header_reg;
        raw_remaining_next   = raw_remaining_reg;
        in_run_next          = in_run_reg;
        run_length_next      = run_length_reg;
        byte_position_next   = byte_position_reg;
        pixel_acc_next       = pixel_acc_reg;
        emit                 = 1'b0;
        out_count_next       = {{(REPEAT_WIDTH-1){1'b0}}, 1'b1};

        if (in_accept)
        begin
            if (rle_enable_reg && awaiting_header_reg && byte_position_reg == 2'd0)
            begin
                // Packet header: headers only sit between whole pixels.
                in_run_next          = s_axis_tdata[RUN_FLAG_BIT];
                awaiting_header_next = 1'b0;
                if (s_axis_tdata[RUN_FLAG_BIT])
                begin
                    run_length_next = {1'b0, s_axis_tdata[COUNT_WIDTH-1:0]} + 1'b1;
                end
                else
                begin
                    raw_remaining_next = s_axis_tdata[COUNT_WIDTH-1:0];
                end
            end
            else
            begin
                // The alpha byte in the fourth position is never kept.
                unique case (byte_position_reg)
                    2'd0:    pixel_acc_next[7:0]   = s_axis_tdata;
                    2'd1:    pixel_acc_next[15:8]  = s_axis_tdata;
                    2'd2:    pixel_acc_next[23:16] = s_axis_tdata;
                    default: pixel_acc_next        = pixel_acc_reg;
                endcase

                if (byte_position_reg < last_position(pixel_format_reg))
                begin
                    byte_position_next = byte_position_reg + 2'd1;
                end
                else
                begin
                    byte_position_next = 2'd0;
                    emit               = 1'b1;
                    if (rle_enable_reg)
                    begin
                        if (in_run_reg)
                        begin
                            out_count_next       = run_length_reg;
                            in_run_next          = 1'b0;
                            awaiting_header_next = 1'b1;
                        end
                        else if (raw_remaining_reg == '0)
                        begin
                            awaiting_header_next = 1'b1;
                        end
                        else
                        begin
                            raw_remaining_next = raw_remaining_reg - 1'b1;
                        end
                    end
                end
            end
        end

        out_word_next = finished_word(pixel_format_reg, pixel_acc_next);

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_enable_reg      <= 1'b0;
            pixel_format_reg    <= FMT_WORD16;
            awaiting_header_reg <= 1'b1;
            raw_remaining_reg   <= '0;
            in_run_reg          <= 1'b0;
            run_length_reg      <= {{(REPEAT_WIDTH-1){1'b0}}, 1'b1};
            byte_position_reg   <= 2'd0;
            pixel_acc_reg       <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (paddr[2] == REG_PIXEL_FORMAT)
                begin
                    pixel_format_reg <= pwdata[1:0];
                end
                else
                begin
                    rle_enable_reg <= pwdata[0];
                end
            end
            awaiting_header_reg <= awaiting_header_next;
            raw_remaining_reg   <= raw_remaining_next;
            in_run_reg          <= in_run_next;
            run_length_reg      <= run_length_next;
            byte_position_reg   <= byte_position_next;
            pixel_acc_reg       <= pixel_acc_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Output payload needs no reset; it loads only with a finished pixel.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg  <= out_word_next;
            out_count_reg <= out_count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_word_reg};

endmodule

### test/tb_tga_rle_pixel_decoder.sv
module tb_tga_rle_pixel_decoder;

    import tga_rle_pkg::*;

    // The package leaves the fourth format code unnamed; the decoder treats it
    // as the 16-bit word format, and it is exercised as such here.
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PHASE_COUNT    = 9;
    localparam int unsigned PHASE_BYTES    = 140;

    // One decoded pixel as it leaves the block.
    typedef struct packed {
        logic [15:0] word;
        logic [7:0]  count;
    } pixel_t;

    // The checker keeps its own copy of the two registers and of the packet and
    // pixel assembly state. Every accepted byte advances that state, and each
    // completed pixel is queued as the next pixel the block must emit.
    class rle_pixel_checker;
        logic        rle_on;
        logic [1:0]  fmt;
        logic        want_header;
        logic [6:0]  raw_left;
        logic        run_pending;
        logic [7:0]  run_count;
        logic [1:0]  pos;
        logic [23:0] acc;
        pixel_t      pixels_due[$];
        int          errors;

        function new();
            rle_on      = 1'b0;
            fmt         = FMT_WORD16;
            want_header = 1'b1;
            raw_left    = '0;
            run_pending = 1'b0;
            run_count   = 8'd1;
            pos         = '0;
            acc         = '0;
            errors      = 0;
        endfunction

        function void write_reg(input logic idx, input logic [31:0] value);
            if (idx == REG_RLE_ENABLE)
                rle_on = value[0];
            else
                fmt = value[1:0];
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        function void take_byte(input logic [7:0] b);
            logic [1:0] last;
            pixel_t     px;
            // A header is only taken between pixels, never in the middle of one.
            if (rle_on && want_header && pos == 2'd0)
            begin
                run_pending = b[7];
                if (b[7])
                    run_count = {1'b0, b[6:0]} + 8'd1;
                else
                    raw_left = b[6:0];
                want_header = 1'b0;
                return;
            end
            // The alpha byte of a 32-bit pixel is never kept.
            if (pos != 2'd3)
                acc[pos*8 +: 8] = b;
            case (fmt)
                FMT_BGR24:  last = 2'd2;
                FMT_BGRA32: last = 2'd3;
                default:    last = 2'd1;
            endcase
            // A pixel ends on the first byte at or past the format's last
            // position, which matters when the format changed mid-pixel.
            if (pos < last)
            begin
                pos = pos + 2'd1;
                return;
            end
            pos = 2'd0;
            px.count = 8'd1;
            // With RLE off the packet state is frozen, so a later re-enable
            // picks the packet up where it stood.
            if (rle_on)
            begin
                if (run_pending)
                begin
                    px.count    = run_count;
                    run_pending = 1'b0;
                    want_header = 1'b1;
                end
                else if (raw_left == 7'd0)
                    want_header = 1'b1;
                else
                    raw_left = raw_left - 7'd1;
            end
            if (fmt == FMT_BGR24 || fmt == FMT_BGRA32)
                px.word = {1'b0, acc[23:19], acc[15:11], acc[7:3]};
            else
                px.word = acc[15:0];
            pixels_due.push_back(px);
        endfunction

        function void match_pixel(input logic [23:0] data);
            pixel_t want;
            if (pixels_due.size() == 0)
            begin
                $display("%0t: unexpected pixel, got word %h count %0d",
                         $time, data[15:0], data[23:16]);
                errors++;
                return;
            end
            want = pixels_due.pop_front();
            if (data[15:0] !== want.word)
            begin
                $display("%0t: pixel_word mismatch, expected %h, got %h",
                         $time, want.word, data[15:0]);
                errors++;
            end
            if (data[23:16] !== want.count)
            begin
                $display("%0t: repeat_count mismatch, expected %0d, got %0d",
                         $time, want.count, data[23:16]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [DATA_WIDTH-1:0] pwdata = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: data_byte[7:0].
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: pixel_word[15:0], repeat_count[23:16].
    logic [23:0] m_axis_tdata;

    rle_pixel_checker scoreboard = new();

    // Idle percentages in force for the current phase, and the request that
    // makes the receiver hold off for a long stretch.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_request = 1'b0;

    int unsigned bytes_taken = 0;
    int unsigned pixels_seen = 0;
    int unsigned runs_seen = 0;
    int unsigned quiet_cycles = 0;

    always #5 clk = ~clk;

    tga_rle_pixel_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Transaction monitor. Inputs change only through nonblocking assignments
    // at the clock edge, so the values read here are those that stood before
    // the edge. Each accepted byte goes to the checker before the result of
    // this edge is matched; a byte never produces a result at its own edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                scoreboard.take_byte(s_axis_tdata);
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                scoreboard.match_pixel(m_axis_tdata);
                pixels_seen++;
                if (m_axis_tdata[23:16] > 8'd1)
                    runs_seen++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: the run is abandoned when nothing moves on either stream for
    // far longer than the longest legitimate stall.
    initial
    begin
        do
            @(posedge clk);
        while (quiet_cycles < WATCHDOG_LIMIT);
        $display("%0t: watchdog expired with %0d pixels outstanding",
                 $time, scoreboard.pending());
        $display("status: fail");
        $finish;
    end

    // Receiver. It stalls at random with the current idle percentage, or holds
    // off completely for a counted stretch when asked, so that the decoder's
    // output register fills and the byte stream backs up.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one byte and returns at the edge where it is accepted. tvalid is
    // left high so that back-to-back bytes need no second assignment in the
    // same time step; it is only lowered during gaps or by drain.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stops the byte stream and waits until every predicted pixel has come
    // out, then waits out a settle time for a byte that completes no pixel.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (scoreboard.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: a setup phase, then an access phase held until pready.
    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scoreboard.write_reg(idx, value);
    endtask

    // Registers change only with the decoder idle. The decoding state is
    // deliberately not cleared, so a setting may take effect mid-packet or
    // even mid-pixel. The bus goes idle between the two writes.
    task automatic configure(input logic rle, input logic [1:0] fmt);
        drain();
        apb_write(REG_RLE_ENABLE, {31'd0, rle});
        @(posedge clk);
        apb_write(REG_PIXEL_FORMAT, {30'd0, fmt});
    endtask

    // Random byte stream. In RLE mode most of it is well-formed packets: a
    // header followed by exactly the pixel bytes it announces, with random
    // content. The rest is loose bytes that knock the packet framing about.
    task automatic send_stream(input int n_bytes);
        int         sent;
        int         bpp;
        int         npix;
        logic [7:0] hdr;
        sent = 0;
        while (sent < n_bytes)
        begin
            bpp = (scoreboard.fmt == FMT_BGR24) ? 3 :
                  (scoreboard.fmt == FMT_BGRA32) ? 4 : 2;
            if (scoreboard.rle_on && $urandom_range(99) < 85)
            begin
                hdr[7] = 1'($urandom_range(1));
                if (hdr[7] && $urandom_range(1) == 0)
                    hdr[6:0] = 7'($urandom_range(127));
                else if ($urandom_range(24) == 0)
                    hdr[6:0] = 7'($urandom_range(127));
                else
                    hdr[6:0] = 7'($urandom_range(5));
                send_byte(hdr);
                sent++;
                npix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
                repeat (npix * bpp)
                begin
                    send_byte(8'($urandom_range(255)));
                    sent++;
                end
            end
            else
            begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    logic       phase_rle[PHASE_COUNT] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                           1'b0, 1'b1, 1'b0, 1'b1};
    logic [1:0] phase_fmt[PHASE_COUNT] = '{FMT_WORD16, FMT_BGR24, FMT_BGRA32,
                                           FMT_BGR24, FMT_UNUSED, FMT_BGRA32,
                                           FMT_WORD16, FMT_UNUSED, FMT_BGR24};

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with a lightly stalled sender and a heavily
        // stalled receiver.
        send_idle_pct = 8;
        recv_idle_pct = 84;

        // Plain 16-bit words at both extremes of the byte range.
        configure(1'b0, FMT_WORD16);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);

        // 24-bit BGR to RGB555, including the truncated low bits.
        configure(1'b0, FMT_BGR24);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h07);
        send_byte(8'hF8);
        send_byte(8'h08);

        // RLE with the longest run, then a raw packet of one pixel.
        configure(1'b1, FMT_BGRA32);
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);
        send_byte(8'h00);
        send_byte(8'hE7);
        send_byte(8'h18);
        send_byte(8'hC3);
        send_byte(8'h3C);

        // Format changed mid-pixel: three bytes of a 32-bit pixel, then the
        // switch to 16-bit lets the next byte complete it.
        configure(1'b0, FMT_BGRA32);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h81);
        configure(1'b0, FMT_WORD16);
        send_byte(8'h7E);

        // Random phases. The idling pattern moves from a stalled receiver to a
        // stalled sender and finally to full throughput.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p / 3)
                0:
                begin
                    send_idle_pct = 8;
                    recv_idle_pct = 84;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_idle_pct = 8;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            configure(phase_rle[p], phase_fmt[p]);
            if (p == 6)
            begin
                // Back pressure: the receiver stops for a long stretch while
                // bytes keep coming, so the input side must stall.
                hold_request = 1'b1;
                send_stream(PHASE_BYTES);
            end
            else if (p == 4)
            begin
                // The sender pauses mid-phase until the output has caught up.
                send_stream(PHASE_BYTES / 2);
                drain();
                send_stream(PHASE_BYTES / 2);
            end
            else
                send_stream(PHASE_BYTES);
        end

        drain();

        $display("Decoded %0d bytes into %0d pixels (%0d runs) across plain and RLE modes,",
                 bytes_taken, pixels_seen, runs_seen);
        $display("all four format codes, mid-pixel format changes and stalls on both sides.");
        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
